// ----- rtl/tdmh_pkg.sv -----
// Package for the timer deadline min-heap: operation and result codes,
// request and result payload types, sequencer states. No dependencies.
package tdmh_pkg;

    typedef enum logic [2:0] {
        OP_INSERT   = 3'd0,
        OP_DELETE   = 3'd1,
        OP_UPDATE   = 3'd2,
        OP_FIRE     = 3'd3,
        OP_TIMELEFT = 3'd4,
        OP_READ     = 3'd5,
        OP_RSVD6    = 3'd6,
        OP_RSVD7    = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        K_MOVED    = 3'd0,
        K_FIRED    = 3'd1,
        K_REMOVED  = 3'd2,
        K_LEFT     = 3'd3,
        K_DEADLINE = 3'd4,
        K_NONE     = 3'd5,
        K_FULL     = 3'd6,
        K_BADSLOT  = 3'd7
    } kind_t;

    typedef struct packed {
        op_t         op;
        logic [15:0] job_tag;
        logic [47:0] new_deadline;
        logic [5:0]  heap_slot;
        logic [47:0] current_time;
    } req_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] tag_out;
        logic [5:0]  slot_out;
        logic [47:0] time_out;
        logic        last;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_ROOT,
        S_RD_LAST,
        S_RD_SLOT,
        S_DECIDE,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RDL,
        S_DN_RDR,
        S_DN_CMP,
        S_SETTLE,
        S_EMIT
    } state_t;

endpackage

// ----- rtl/tdmh_if.sv -----
// Valid/ready channel interface carrying the request or result payload.
// Depends on nothing; payload is a parameterized type.
interface tdmh_if #(
    parameter type payload_t = logic
) (
    input logic clk
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/tdmh_store.sv -----
// Heap entry memory: one write port, one registered read port.
// Holds a deadline and a tag per slot; depends on nothing.
module tdmh_store #(
    parameter int DEPTH = 64,
    parameter int TIME_BITS = 48,
    parameter int TAG_BITS = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  logic [TIME_BITS-1:0] wdl,
    input  logic [TAG_BITS-1:0]  wtag,
    input  logic [AW-1:0]        raddr,
    output logic [TIME_BITS-1:0] rdl,
    output logic [TAG_BITS-1:0]  rtag
);
    logic [TIME_BITS+TAG_BITS-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= {wdl, wtag};
        end
        {rdl, rtag} <= mem[raddr];
    end
endmodule

// ----- rtl/timer_deadline_min_heap.sv -----
// Timer deadline min-heap top level: sequencer around one entry memory.
// Depends on tdmh_pkg, tdmh_if and tdmh_store.
//
// Every step of a sift is a read of the single memory read port, a
// compare and a write back: a sift up reads the parent and then compares,
// a sift down reads the left child, then the right child, then compares.
// Each move result is staged in the same cycle as its write back;
// a stalled result register holds the sift. One request is in work at a
// time, and a new request is accepted only when the final result of the
// previous one is taken, which may be in the same cycle. The memory needs
// no clearing after reset.
module timer_deadline_min_heap
    import tdmh_pkg::*;
#(
    parameter int HEAP_DEPTH = 64,
    parameter int TIME_BITS = 48,
    parameter int TAG_BITS = 16
) (
    input logic clk,
    input logic rst_n,
    tdmh_if.sink   req,
    tdmh_if.source rsp
);
    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int CW = $clog2(HEAP_DEPTH + 1);

    // Request fields
    logic [2:0]  in_op;
    logic [15:0] in_tag;
    logic [47:0] in_dl;
    logic [5:0]  in_slot;
    logic [47:0] in_now;
    assign in_op   = req.data.op;
    assign in_tag  = req.data.job_tag;
    assign in_dl   = req.data.new_deadline;
    assign in_slot = req.data.heap_slot;
    assign in_now  = req.data.current_time;

    state_t state_reg, state_next, ret_reg, ret_next;
    logic [CW-1:0] count_reg, count_next;
    op_t  op_reg, op_next;
    logic [TIME_BITS-1:0] dl_reg, dl_next, old_reg, old_next, now_reg, now_next;
    logic [TIME_BITS-1:0] ldl_reg, ldl_next;
    logic [TAG_BITS-1:0]  tag_reg, tag_next, ltag_reg, ltag_next;
    logic [AW-1:0] idx_reg, idx_next;

    // Result register
    logic          ovalid_reg, ovalid_next;
    logic [2:0]    okind_reg, okind_next;
    logic [15:0]   otag_reg, otag_next;
    logic [5:0]    oslot_reg, oslot_next;
    logic [47:0]   otime_reg, otime_next;
    logic          olast_reg, olast_next;

    // Memory port
    logic                 we;
    logic [AW-1:0]        waddr, raddr;
    logic [TIME_BITS-1:0] wdl, rdl;
    logic [TAG_BITS-1:0]  wtag, rtag;

    tdmh_store #(
        .DEPTH(HEAP_DEPTH), .TIME_BITS(TIME_BITS), .TAG_BITS(TAG_BITS)
    ) u_store (
        .clk(clk), .we(we), .waddr(waddr), .wdl(wdl), .wtag(wtag),
        .raddr(raddr), .rdl(rdl), .rtag(rtag)
    );

    logic out_free;
    assign out_free  = !ovalid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && out_free;
    assign rsp.valid = ovalid_reg;
    assign rsp.data.kind     = kind_t'(okind_reg);
    assign rsp.data.tag_out  = otag_reg;
    assign rsp.data.slot_out = oslot_reg;
    assign rsp.data.time_out = otime_reg;
    assign rsp.data.last     = olast_reg;

    // Heap index helpers
    logic [AW-1:0] parent_idx;
    logic [AW:0]   left_w, right_w;
    assign parent_idx = AW'((idx_reg - 1'b1) >> 1);
    assign left_w     = {idx_reg, 1'b1};
    assign right_w    = left_w + 1'b1;

    logic [CW-1:0] half_count;
    assign half_count = count_reg >> 1;

    // Registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ret_reg   <= ret_next;
        op_reg    <= op_next;
        dl_reg    <= dl_next;
        old_reg   <= old_next;
        now_reg   <= now_next;
        ldl_reg   <= ldl_next;
        tag_reg   <= tag_next;
        ltag_reg  <= ltag_next;
        idx_reg   <= idx_next;
        okind_reg <= okind_next;
        otag_reg  <= otag_next;
        oslot_reg <= oslot_next;
        otime_reg <= otime_next;
        olast_reg <= olast_next;
    end

    // Sequencer: next state, datapath and result staging
    always_comb
    begin
        logic accept;
        logic [TIME_BITS-1:0] tdl;
        logic [TAG_BITS-1:0]  ttag;
        state_next  = state_reg;
        ret_next    = ret_reg;
        count_next  = count_reg;
        op_next     = op_reg;
        dl_next     = dl_reg;
        old_next    = old_reg;
        now_next    = now_reg;
        ldl_next    = ldl_reg;
        tag_next    = tag_reg;
        ltag_next   = ltag_reg;
        idx_next    = idx_reg;
        ovalid_next = ovalid_reg && !rsp.ready;
        okind_next  = okind_reg;
        otag_next   = otag_reg;
        oslot_next  = oslot_reg;
        otime_next  = otime_reg;
        olast_next  = olast_reg;
        we    = 1'b0;
        waddr = idx_reg;
        wdl   = dl_reg;
        wtag  = tag_reg;
        raddr = idx_reg;
        accept = req.valid && req.ready;
        tdl  = '0;
        ttag = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next   = op_t'(in_op);
                    dl_next   = TIME_BITS'(in_dl);
                    tag_next  = TAG_BITS'(in_tag);
                    now_next  = TIME_BITS'(in_now);
                    okind_next = K_NONE;
                    otag_next  = '0;
                    oslot_next = '0;
                    otime_next = '0;
                    olast_next = 1'b1;
                    case (op_t'(in_op))
                        OP_INSERT:
                        begin
                            if (count_reg == CW'(HEAP_DEPTH))
                            begin
                                okind_next  = K_FULL;
                                ovalid_next = 1'b1;
                            end
                            else
                            begin
                                idx_next   = AW'(count_reg);
                                count_next = count_reg + 1'b1;
                                we    = 1'b1;
                                waddr = AW'(count_reg);
                                wdl   = TIME_BITS'(in_dl);
                                wtag  = TAG_BITS'(in_tag);
                                state_next = S_UP_RD;
                            end
                        end
                        OP_DELETE, OP_UPDATE, OP_READ:
                        begin
                            if (CW'(in_slot) >= count_reg
                                || (HEAP_DEPTH < 64 && {1'b0, in_slot} >= 7'(HEAP_DEPTH)))
                            begin
                                okind_next  = K_BADSLOT;
                                ovalid_next = 1'b1;
                            end
                            else
                            begin
                                idx_next   = AW'(in_slot);
                                raddr      = AW'(in_slot);
                                state_next = S_RD_SLOT;
                            end
                        end
                        OP_FIRE, OP_TIMELEFT:
                        begin
                            if (count_reg == '0)
                            begin
                                ovalid_next = 1'b1;
                            end
                            else
                            begin
                                idx_next   = '0;
                                raddr      = '0;
                                state_next = S_RD_SLOT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // Target entry is on the read port
            S_RD_SLOT:
            begin
                case (op_reg)
                    OP_READ:
                    begin
                        okind_next = K_DEADLINE;
                        otime_next = 48'(rdl);
                        ret_next   = S_IDLE;
                        state_next = S_EMIT;
                    end
                    OP_TIMELEFT:
                    begin
                        okind_next = K_LEFT;
                        otime_next = (rdl > now_reg) ? 48'(rdl - now_reg) : '0;
                        ret_next   = S_IDLE;
                        state_next = S_EMIT;
                    end
                    OP_FIRE:
                    begin
                        if (rdl > now_reg)
                        begin
                            ret_next   = S_IDLE;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            old_next   = rdl;
                            okind_next = K_FIRED;
                            otag_next  = 16'(rtag);
                            otime_next = 48'(rdl);
                            state_next = S_RD_LAST;
                        end
                    end
                    OP_UPDATE:
                    begin
                        we = 1'b1;
                        if (dl_reg < rdl)
                        begin
                            state_next = S_UP_RD;
                        end
                        else
                        begin
                            state_next = S_DN_RDL;
                        end
                    end
                    default:
                    begin
                        old_next   = rdl;
                        okind_next = K_REMOVED;
                        otag_next  = 16'(rtag);
                        otime_next = 48'(rdl);
                        state_next = S_RD_LAST;
                    end
                endcase
            end

            // Hand out the removal result, then pull the last entry
            S_RD_LAST:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    count_next  = count_reg - 1'b1;
                    if (count_next == '0 || CW'(idx_reg) == count_next)
                    begin
                        olast_next = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        olast_next = 1'b0;
                        raddr      = AW'(count_next);
                        state_next = S_DECIDE;
                    end
                end
            end

            // Last entry fills the hole; choose direction
            S_DECIDE:
            begin
                dl_next  = rdl;
                tag_next = rtag;
                we   = 1'b1;
                wdl  = rdl;
                wtag = rtag;
                state_next = (rdl < old_reg) ? S_UP_RD : S_DN_RDL;
            end

            // Sift up: read parent
            S_UP_RD:
            begin
                if (idx_reg == '0)
                begin
                    state_next = S_SETTLE;
                end
                else
                begin
                    raddr      = parent_idx;
                    state_next = S_UP_CMP;
                end
            end

            S_UP_CMP:
            begin
                if (dl_reg < rdl)
                begin
                    if (out_free)
                    begin
                        we   = 1'b1;
                        wdl  = rdl;
                        wtag = rtag;
                        ovalid_next = 1'b1;
                        okind_next  = K_MOVED;
                        otag_next   = 16'(rtag);
                        oslot_next  = 6'(idx_reg);
                        otime_next  = '0;
                        olast_next  = 1'b0;
                        idx_next    = parent_idx;
                        state_next  = S_UP_RD;
                    end
                    else
                    begin
                        raddr = parent_idx;
                    end
                end
                else
                begin
                    state_next = S_SETTLE;
                end
            end

            // Sift down: read left child
            S_DN_RDL:
            begin
                if (CW'(idx_reg) >= half_count)
                begin
                    state_next = S_SETTLE;
                end
                else
                begin
                    raddr      = AW'(left_w);
                    state_next = S_DN_RDR;
                end
            end

            S_DN_RDR:
            begin
                ldl_next  = rdl;
                ltag_next = rtag;
                raddr     = AW'(right_w);
                state_next = S_DN_CMP;
            end

            S_DN_CMP:
            begin
                tdl  = ldl_reg;
                ttag = ltag_reg;
                if ((CW + 1)'(right_w) < (CW + 1)'(count_reg) && rdl < ldl_reg)
                begin
                    tdl  = rdl;
                    ttag = rtag;
                end
                if (dl_reg < tdl)
                begin
                    state_next = S_SETTLE;
                end
                else if (out_free)
                begin
                    we   = 1'b1;
                    wdl  = tdl;
                    wtag = ttag;
                    ovalid_next = 1'b1;
                    okind_next  = K_MOVED;
                    otag_next   = 16'(ttag);
                    oslot_next  = 6'(idx_reg);
                    otime_next  = '0;
                    olast_next  = 1'b0;
                    idx_next    = (tdl == ldl_reg && ttag == ltag_reg
                                   && !((CW + 1)'(right_w) < (CW + 1)'(count_reg)
                                        && rdl < ldl_reg))
                                  ? AW'(left_w) : AW'(right_w);
                    state_next  = S_DN_RDL;
                end
                else
                begin
                    raddr = AW'(right_w);
                end
            end

            // Write the moving job home and report it
            S_SETTLE:
            begin
                if (out_free)
                begin
                    we = 1'b1;
                    ovalid_next = 1'b1;
                    okind_next  = K_MOVED;
                    otag_next   = 16'(tag_reg);
                    oslot_next  = 6'(idx_reg);
                    otime_next  = '0;
                    olast_next  = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    olast_next  = 1'b1;
                    state_next  = ret_reg;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(HEAP_DEPTH))
        else $error("entry count above depth");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !req.ready)
        else $error("request accepted while busy");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
        (count_reg == $past(count_reg) + 1'b1 || count_reg == $past(count_reg) - 1'b1))
        else $error("entry count jumped");
    a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && !rsp.ready) |=> ovalid_reg && $stable(okind_reg))
        else $error("result dropped under stall");
endmodule

// ----- tb/sv/tdmh_checker.sv -----
// Checker that predicts heap results from accepted requests and compares them.
// Depends on tdmh_pkg.
module tdmh_checker
    import tdmh_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_ready,
    input  req_t req_data,
    input  logic rsp_valid,
    input  logic rsp_ready,
    input  rsp_t rsp_data,
    output int   fail_count,
    output int   pending,
    output int   heap_count,
    output int   results_seen
);
    localparam int DEPTH = 64;

    logic [47:0] due_mem [DEPTH];
    logic [15:0] tag_mem [DEPTH];
    int          count;
    rsp_t        expected_q [$];

    function automatic void push_result(kind_t k, logic [15:0] tg, int slot, logic [47:0] t);
        rsp_t r;
        r.kind = k;
        r.tag_out = tg;
        r.slot_out = slot[5:0];
        r.time_out = t;
        r.last = 1'b0;
        expected_q.push_back(r);
    endfunction

    // Walk toward the root, reporting each displaced parent, then the settled job
    function automatic void rise(int idx);
        logic [47:0] d;
        logic [15:0] tg;
        int          p;
        d = due_mem[idx];
        tg = tag_mem[idx];
        while (idx > 0 && d < due_mem[(idx - 1) / 2]) begin
            p = (idx - 1) / 2;
            due_mem[idx] = due_mem[p];
            tag_mem[idx] = tag_mem[p];
            push_result(K_MOVED, tag_mem[idx], idx, '0);
            idx = p;
        end
        due_mem[idx] = d;
        tag_mem[idx] = tg;
        push_result(K_MOVED, tg, idx, '0);
    endfunction

    // Walk toward the leaves, pulling up the earlier child
    function automatic void sink_down(int idx);
        logic [47:0] d;
        logic [15:0] tg;
        int          half;
        int          lc;
        int          rc;
        int          y;
        half = count / 2;
        d = due_mem[idx];
        tg = tag_mem[idx];
        while (idx < half) begin
            lc = idx * 2 + 1;
            rc = idx * 2 + 2;
            y = lc;
            if (rc < count && due_mem[rc] < due_mem[lc])
                y = rc;
            if (d < due_mem[y])
                break;
            due_mem[idx] = due_mem[y];
            tag_mem[idx] = tag_mem[y];
            push_result(K_MOVED, tag_mem[idx], idx, '0);
            idx = y;
        end
        due_mem[idx] = d;
        tag_mem[idx] = tg;
        push_result(K_MOVED, tg, idx, '0);
    endfunction

    function automatic void take_out(int idx, kind_t k);
        logic [47:0] old_d;
        old_d = due_mem[idx];
        push_result(k, tag_mem[idx], 0, old_d);
        count--;
        if (count > 0 && idx != count) begin
            due_mem[idx] = due_mem[count];
            tag_mem[idx] = tag_mem[count];
            if (due_mem[idx] < old_d)
                rise(idx);
            else
                sink_down(idx);
        end
    endfunction

    function automatic void predict(req_t r);
        int          before_n;
        int          s;
        logic [47:0] old_d;
        before_n = expected_q.size();
        s = r.heap_slot;
        case (r.op)
            OP_INSERT:
                if (count >= DEPTH)
                    push_result(K_FULL, '0, 0, '0);
                else begin
                    due_mem[count] = r.new_deadline;
                    tag_mem[count] = r.job_tag;
                    count++;
                    rise(count - 1);
                end
            OP_DELETE:
                if (s >= count)
                    push_result(K_BADSLOT, '0, 0, '0);
                else
                    take_out(s, K_REMOVED);
            OP_UPDATE:
                if (s >= count)
                    push_result(K_BADSLOT, '0, 0, '0);
                else begin
                    old_d = due_mem[s];
                    due_mem[s] = r.new_deadline;
                    tag_mem[s] = r.job_tag;
                    if (r.new_deadline < old_d)
                        rise(s);
                    else
                        sink_down(s);
                end
            OP_FIRE:
                if (count == 0 || due_mem[0] > r.current_time)
                    push_result(K_NONE, '0, 0, '0);
                else
                    take_out(0, K_FIRED);
            OP_TIMELEFT:
                if (count == 0)
                    push_result(K_NONE, '0, 0, '0);
                else
                    push_result(K_LEFT, '0, 0, (due_mem[0] > r.current_time) ?
                                due_mem[0] - r.current_time : '0);
            OP_READ:
                if (s >= count)
                    push_result(K_BADSLOT, '0, 0, '0);
                else
                    push_result(K_DEADLINE, '0, 0, due_mem[s]);
            default: ;
        endcase
        if (expected_q.size() > before_n)
            expected_q[expected_q.size() - 1].last = 1'b1;
    endfunction

    // Predict on each accepted request, compare each accepted result
    always @(posedge clk or negedge rst_n) begin
        rsp_t e;
        if (!rst_n) begin
            count = 0;
            expected_q.delete();
            fail_count <= 0;
            results_seen <= 0;
        end else begin
            if (req_valid && req_ready)
                predict(req_data);
            if (rsp_valid && rsp_ready) begin
                results_seen <= results_seen + 1;
                if (expected_q.size() == 0) begin
                    $error("unexpected result: kind %0d tag %0h", rsp_data.kind,
                           rsp_data.tag_out);
                    fail_count <= fail_count + 1;
                end else begin
                    e = expected_q.pop_front();
                    if (rsp_data.kind !== e.kind
                        || rsp_data.tag_out !== e.tag_out
                        || rsp_data.slot_out !== e.slot_out
                        || rsp_data.time_out !== e.time_out
                        || rsp_data.last !== e.last)
                        fail_count <= fail_count + 1;
                    if (rsp_data.kind !== e.kind)
                        $error("kind: expected %0d, got %0d", e.kind, rsp_data.kind);
                    if (rsp_data.tag_out !== e.tag_out)
                        $error("tag_out: expected %0h, got %0h", e.tag_out,
                               rsp_data.tag_out);
                    if (rsp_data.slot_out !== e.slot_out)
                        $error("slot_out: expected %0d, got %0d", e.slot_out,
                               rsp_data.slot_out);
                    if (rsp_data.time_out !== e.time_out)
                        $error("time_out: expected %0h, got %0h", e.time_out,
                               rsp_data.time_out);
                    if (rsp_data.last !== e.last)
                        $error("last: expected %0b, got %0b", e.last, rsp_data.last);
                end
            end
        end
        pending <= expected_q.size();
        heap_count <= count;
    end
endmodule

// ----- tb/sv/tb_timer_deadline_min_heap.sv -----
// Testbench top for the timer deadline min-heap: clock, reset, request stimulus and verdict.
// Depends on tdmh_pkg, tdmh_if, tdmh_checker and the block.
module tb_timer_deadline_min_heap;
    import tdmh_pkg::*;

    localparam int STALL_LIMIT = 4000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic no_idle = 1'b0;
    int   fail_count;
    int   pending;
    int   heap_count;
    int   results_seen;
    int   requests_sent = 0;
    int   quiet_cycles = 0;

    tdmh_if #(.payload_t(req_t)) req_ch (clk);
    tdmh_if #(.payload_t(rsp_t)) rsp_ch (clk);

    timer_deadline_min_heap uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    tdmh_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_ch.valid),
        .req_ready    (req_ch.ready),
        .req_data     (req_ch.data),
        .rsp_valid    (rsp_ch.valid),
        .rsp_ready    (rsp_ch.ready),
        .rsp_data     (rsp_ch.data),
        .fail_count   (fail_count),
        .pending      (pending),
        .heap_count   (heap_count),
        .results_seen (results_seen)
    );

    always #10 clk = ~clk;

    initial
    begin
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        rsp_ch.ready = 1'b0;
    end

    // Drop ready at random unless in the no-idle stretch
    always @(posedge clk)
    begin
        rsp_ch.ready <= no_idle || ($urandom_range(0, 99) >= 37);
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else if (rst_n)
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb_timer_deadline_min_heap: errors");
            $finish;
        end
    end

    function automatic logic [47:0] pick_deadline();
        case ($urandom_range(0, 3))
            0: pick_deadline = 48'({$urandom(), $urandom()});
            1: pick_deadline = 48'($urandom_range(0, 7));
            default: pick_deadline = 48'($urandom_range(0, 1000));
        endcase
    endfunction

    // Hand one request over, idling first at random
    task automatic send(op_t op, logic [15:0] tg, logic [47:0] d, logic [5:0] s,
                        logic [47:0] now);
        req_t r;
        r.op = op;
        r.job_tag = tg;
        r.new_deadline = d;
        r.heap_slot = s;
        r.current_time = now;
        if (!no_idle && $urandom_range(0, 99) < 37)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data <= r;
        do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
        requests_sent++;
    endtask

    task automatic send_random(int w_insert);
        int          roll;
        logic [5:0]  s;
        logic [47:0] now;
        roll = $urandom_range(0, 99);
        s = (heap_count > 0 && $urandom_range(0, 9) != 0) ?
            6'($urandom_range(0, heap_count - 1)) : 6'($urandom());
        now = ($urandom_range(0, 2) == 0) ? 48'({$urandom(), $urandom()})
                                          : 48'($urandom_range(0, 1200));
        if (roll < w_insert)
            send(OP_INSERT, 16'($urandom()), pick_deadline(), s, now);
        else
            send(op_t'($urandom_range(1, 7)), 16'($urandom()), pick_deadline(), s, now);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty heap: bad slots and nothing due
        send(OP_READ, 16'h0, 48'h0, 6'd0, 48'h0);
        send(OP_DELETE, 16'h0, 48'h0, 6'd63, 48'h0);
        send(OP_UPDATE, 16'hffff, 48'h5, 6'd0, 48'h0);
        send(OP_FIRE, 16'h0, 48'h0, 6'd0, 48'hffff_ffff_ffff);
        send(OP_TIMELEFT, 16'h0, 48'h0, 6'd0, 48'h0);
        // Extremes and equal deadlines
        send(OP_INSERT, 16'hffff, 48'hffff_ffff_ffff, 6'd0, 48'h0);
        send(OP_INSERT, 16'h0000, 48'h0, 6'd0, 48'h0);
        send(OP_INSERT, 16'h1234, 48'd100, 6'd0, 48'h0);
        send(OP_INSERT, 16'h1235, 48'd100, 6'd0, 48'h0);
        send(OP_INSERT, 16'h1236, 48'd50, 6'd0, 48'h0);
        send(OP_READ, 16'h0, 48'h0, 6'd2, 48'h0);
        send(OP_READ, 16'h0, 48'h0, 6'd5, 48'h0);
        // Time left before and past the root deadline; updates, fires, deletes, reserved codes
        send(OP_TIMELEFT, 16'h0, 48'h0, 6'd0, 48'hffff_ffff_ffff);
        send(OP_UPDATE, 16'haaaa, 48'd500, 6'd0, 48'h0);
        send(OP_UPDATE, 16'h5555, 48'd1, 6'd4, 48'h0);
        send(OP_TIMELEFT, 16'h0, 48'h0, 6'd0, 48'h0);
        send(OP_FIRE, 16'h0, 48'h0, 6'd0, 48'h0);
        send(OP_FIRE, 16'h0, 48'h0, 6'd0, 48'd60);
        send(OP_DELETE, 16'h0, 48'h0, 6'd3, 48'h0);
        send(OP_DELETE, 16'h0, 48'h0, 6'd0, 48'h0);
        send(OP_RSVD6, 16'hffff, 48'hffff_ffff_ffff, 6'd63, 48'hffff_ffff_ffff);
        send(OP_RSVD7, 16'h0, 48'h0, 6'd0, 48'h0);

        // Mixed traffic, growing the heap
        repeat (130) send_random(45);

        // Hold until every expected result is in
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);

        // Fill to capacity without idling, then overflow
        no_idle <= 1'b1;
        repeat (64 - heap_count + 3)
            send(OP_INSERT, 16'($urandom()), pick_deadline(), 6'd0, 48'h0);
        send(OP_READ, 16'h0, 48'h0, 6'd63, 48'h0);
        send(OP_DELETE, 16'h0, 48'h0, 6'd63, 48'h0);
        no_idle <= 1'b0;

        // Traffic weighted less toward inserts
        repeat (130) send_random(30);

        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);

        $display("covered %0d requests and %0d results: empty, full, bad slot,", requests_sent,
                 results_seen);
        $display("ties, extreme deadlines, sifts both ways, fire and time-left queries");
        if (fail_count == 0 && pending == 0)
            $display("tb_timer_deadline_min_heap: clean");
        else
            $display("tb_timer_deadline_min_heap: errors");
        $finish;
    end
endmodule

// ----- files.f -----
rtl/tdmh_pkg.sv
rtl/tdmh_if.sv
rtl/tdmh_store.sv
rtl/timer_deadline_min_heap.sv
tb/sv/tdmh_checker.sv
tb/sv/tb_timer_deadline_min_heap.sv
